>>> hdl/bm3_pkg.sv
// bm3_pkg: shared constants, codes and token types for the 3x3 binary morphology core
// no dependencies; imported by every module of the core but bm3_ram
`timescale 1ns / 1ps

package bm3_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OPERATION      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_SHAPE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LUMA_THRESHOLD = 3'd4;

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam logic [7:0] LUMA_THRESHOLD_RST = 8'd128;

  localparam logic [1:0] OP_DILATE = 2'd0;
  localparam logic [1:0] OP_ERODE  = 2'd1;
  localparam logic [1:0] OP_OPEN   = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  localparam logic SHAPE_CROSS  = 1'b0;
  localparam logic SHAPE_SQUARE = 1'b1;

  localparam logic KIND_DILATE = 1'b0;
  localparam logic KIND_ERODE  = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [7:0] LEVEL_FG = 8'd0;
  localparam logic [7:0] LEVEL_BG = 8'd255;

  // item from the front end to the back end
  typedef struct packed {
    logic [7:0] luma;
    logic       restart;
    logic       emit;
    logic       last;
  } tok_t;

  // binary item between the window stages
  typedef struct packed {
    logic bg;
    logic restart;
    logic emit;
    logic last;
  } stok_t;

endpackage

>>> hdl/bm3_in_if.sv
// bm3_in_if: input pixel channel, valid/ready with command and rgb payload
// no dependencies
`timescale 1ns / 1ps

interface bm3_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink (input valid, cmd, red, green, blue, output ready);
endinterface

>>> hdl/bm3_out_if.sv
// bm3_out_if: result channel, valid/ready with level and frame end flag
// no dependencies
`timescale 1ns / 1ps

interface bm3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       frame_end;

  modport source (output valid, level, frame_end, input ready);
  modport sink (input valid, level, frame_end, output ready);
endinterface

>>> hdl/bm3_ram.sv
// bm3_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bm3_front.sv
// bm3_front: takes pixel and flush items, computes luma, tracks frame positions
// and pending results, and issues tokens to the back end; uses bm3_pkg, bm3_in_if
`timescale 1ns / 1ps

module bm3_front import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
  input  logic [1:0]                        op,
  bm3_in_if.sink                            pixels,
  output logic                              tok_valid,
  input  logic                              tok_ready,
  output tok_t                              tok
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH+1);
  localparam int HT_W  = $clog2(MAX_HEIGHT+1);
  localparam int CNT_W = $clog2(2*MAX_WIDTH+3);

  localparam logic [24:0] K_RED   = 25'd13933;
  localparam logic [24:0] K_GREEN = 25'd46871;
  localparam logic [24:0] K_BLUE  = 25'd4732;
  localparam logic [24:0] K_HALF  = 25'd32768;

  logic [COL_W-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [ROW_W-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [CNT_W-1:0] pending, pending_next, gap, gap_next;
  tok_t             tok_next;
  logic             tok_load;

  logic [24:0]      luma_sum;
  logic [7:0]       luma;
  logic [CNT_W-1:0] lat, pbase, pend_inc, pend_after;
  logic             at_start, drain, is_flush, space, stuff;
  logic [COL_W-1:0] ocol_b, oadv_col, iadv_col;
  logic [ROW_W-1:0] orow_b, oadv_row, iadv_row;
  logic             owrap, icol_wrap, irow_wrap, last, pix_emit;

  assign luma_sum = K_RED * 25'(pixels.red) + K_GREEN * 25'(pixels.green)
                  + K_BLUE * 25'(pixels.blue) + K_HALF;
  assign luma     = luma_sum[23:16];

  assign lat = (op == OP_DILATE || op == OP_ERODE) ? CNT_W'(width) + CNT_W'(1)
                                                  : (CNT_W'(width) << 1) + CNT_W'(2);

  assign at_start = (in_col == '0) && (in_row == '0);
  assign drain    = at_start && (pending != '0);
  assign is_flush = (pixels.cmd == CMD_FLUSH);
  assign space    = !tok_valid || tok_ready;
  // the first drain flush of a frame shorter than the latency first pushes silent tokens
  assign stuff    = is_flush && drain && (gap != '0);
  assign pixels.ready = space && !stuff;

  always_comb begin
    ocol_b = out_col;
    orow_b = out_row;
    pbase  = pending;
    // a pixel opening a frame drops whatever is still pending
    if (!is_flush && drain) begin
      ocol_b = '0;
      orow_b = '0;
      pbase  = '0;
    end
    owrap     = (WD_W'(ocol_b) + WD_W'(1)) >= width;
    oadv_col  = owrap ? '0 : ocol_b + COL_W'(1);
    oadv_row  = orow_b;
    if (owrap) begin
      oadv_row = ((HT_W'(orow_b) + HT_W'(1)) >= height) ? '0 : orow_b + ROW_W'(1);
    end
    last      = (HT_W'(orow_b) == height - HT_W'(1)) && (WD_W'(ocol_b) == width - WD_W'(1));

    icol_wrap = (WD_W'(in_col) + WD_W'(1)) >= width;
    irow_wrap = (HT_W'(in_row) + HT_W'(1)) >= height;
    iadv_col  = icol_wrap ? '0 : in_col + COL_W'(1);
    iadv_row  = in_row;
    if (icol_wrap) begin
      iadv_row = irow_wrap ? '0 : in_row + ROW_W'(1);
    end

    pend_inc   = pbase + CNT_W'(1);
    pix_emit   = pend_inc > lat;
    pend_after = pix_emit ? pbase : pend_inc;

    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pending_next = pending;
    gap_next     = gap;
    tok_load     = 1'b0;
    tok_next     = tok;

    if (pixels.valid && space) begin
      if (!is_flush) begin
        tok_load     = 1'b1;
        tok_next     = '{luma: luma, restart: at_start, emit: pix_emit, last: last};
        in_col_next  = iadv_col;
        in_row_next  = iadv_row;
        out_col_next = pix_emit ? oadv_col : ocol_b;
        out_row_next = pix_emit ? oadv_row : orow_b;
        pending_next = pend_after;
        gap_next     = (icol_wrap && irow_wrap) ? lat - pend_after : '0;
      end else if (drain) begin
        tok_load = 1'b1;
        if (gap != '0) begin
          gap_next = gap - CNT_W'(1);
          tok_next = '{luma: luma, restart: 1'b0, emit: 1'b0, last: 1'b0};
        end else begin
          tok_next     = '{luma: luma, restart: 1'b0, emit: 1'b1, last: last};
          out_col_next = oadv_col;
          out_row_next = oadv_row;
          pending_next = pending - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      pending   <= '0;
      gap       <= '0;
      tok_valid <= 1'b0;
    end else if (restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
      gap     <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      pending <= pending_next;
      gap     <= gap_next;
      if (tok_load) begin
        tok_valid <= 1'b1;
      end else if (tok_ready) begin
        tok_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_load) begin
      tok <= tok_next;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst) pending <= lat)
    else $error("pending count above latency");
  a_gap_at_start: assert property (@(posedge clk) disable iff (rst)
    gap != '0 |-> at_start)
    else $error("silent tail tokens owed away from frame start");

endmodule

>>> hdl/bm3_queue.sv
// bm3_queue: short token fifo decoupling the front end from the back end
// uses bm3_pkg
`timescale 1ns / 1ps

module bm3_queue import bm3_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_tok   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_tok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

>>> hdl/bm3_stage.sv
// bm3_stage: one 3x3 dilate or erode pass over a binary raster stream, two line
// stores in a ram and a sliding window; uses bm3_pkg, bm3_ram
`timescale 1ns / 1ps

module bm3_stage import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  input  logic                            shape,
  input  logic                            kind,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  stok_t                           in_tok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stok_t                           out_tok
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WD_W   = $clog2(MAX_WIDTH+1);
  localparam int HT_W   = $clog2(MAX_HEIGHT+1);
  localparam int FILL_W = $clog2(MAX_WIDTH+3);

  // token position bookkeeping
  logic [COL_W-1:0]  next_col, ccol;
  logic [FILL_W-1:0] fill;
  logic [HT_W-1:0]   crow;

  // window stage
  logic              b_valid, b_filled, b_first, b_fwd;
  stok_t             b_tok;
  logic [COL_W-1:0]  b_col, b_ccol;
  logic [HT_W-1:0]   b_crow;
  logic [1:0]        b_fwd_data;
  logic [2:0]        win_l, win_m;

  logic [COL_W-1:0]  col_this, cen_col;
  logic [HT_W-1:0]   cen_row;
  logic [FILL_W-1:0] fill_this, fill_lim;
  logic              first_fill, filled_this, accept, b_leave, fwd_set, ccwrap;
  logic [1:0]        ram_rdata, rd;
  logic [2:0]        col3;
  logic              top_ok, bot_ok, left_ok, right_ok, bg;
  logic [8:0]        vals, inc, shape_mask;

  assign col_this    = in_tok.restart ? '0 : next_col;
  assign fill_this   = in_tok.restart ? '0 : fill;
  assign fill_lim    = FILL_W'(width) + FILL_W'(1);
  assign first_fill  = (fill_this == fill_lim);
  assign filled_this = (fill_this >= fill_lim);
  assign cen_col     = first_fill ? '0 : ccol;
  assign cen_row     = first_fill ? '0 : crow;
  assign ccwrap      = (WD_W'(cen_col) + WD_W'(1)) >= width;

  assign b_leave  = b_valid && (!b_filled || !out_valid || out_ready);
  assign in_ready = !b_valid || b_leave;
  assign accept   = in_valid && in_ready;
  // only a width of one, or a restart onto column zero, reads what is written now
  assign fwd_set  = accept && b_leave && (col_this == b_col);

  // rd[0] holds the line above the new pixel, rd[1] the line above that
  assign rd   = b_fwd ? b_fwd_data : ram_rdata;
  assign col3 = {rd[1], rd[0], b_tok.bg};

  bm3_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (b_leave),
    .waddr (b_col),
    .wdata ({rd[0], b_tok.bg}),
    .re    (accept),
    .raddr (col_this),
    .rdata (ram_rdata)
  );

  assign top_ok   = (b_crow != '0);
  assign bot_ok   = ((HT_W+1)'(b_crow) + (HT_W+1)'(1)) < (HT_W+1)'(height);
  assign left_ok  = (b_ccol != '0);
  assign right_ok = (WD_W'(b_ccol) + WD_W'(1)) < width;

  // rows top, middle, bottom; columns left, middle, right
  assign vals = {win_l[2], win_m[2], col3[2],
                 win_l[1], win_m[1], col3[1],
                 win_l[0], win_m[0], col3[0]};
  assign shape_mask = (shape == SHAPE_SQUARE) ? 9'b111_111_111 : 9'b010_111_010;
  assign inc = shape_mask & {top_ok & left_ok, top_ok, top_ok & right_ok,
                             left_ok, 1'b1, right_ok,
                             bot_ok & left_ok, bot_ok, bot_ok & right_ok};
  assign bg  = (kind == KIND_ERODE) ? |(vals & inc) : &(vals | ~inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_col  <= '0;
      fill      <= '0;
      crow      <= '0;
      ccol      <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        b_valid  <= 1'b1;
        next_col <= ((WD_W'(col_this) + WD_W'(1)) >= width) ? '0 : col_this + COL_W'(1);
        fill     <= (fill_this > fill_lim) ? fill_this : fill_this + FILL_W'(1);
        if (filled_this) begin
          ccol <= ccwrap ? '0 : cen_col + COL_W'(1);
          crow <= (ccwrap && cen_row < height) ? cen_row + HT_W'(1) : cen_row;
        end
      end else if (b_leave) begin
        b_valid <= 1'b0;
      end
      if (b_leave && b_filled) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_tok      <= in_tok;
      b_col      <= col_this;
      b_filled   <= filled_this;
      b_first    <= first_fill;
      b_ccol     <= cen_col;
      b_crow     <= cen_row;
      b_fwd      <= fwd_set;
      b_fwd_data <= {rd[0], b_tok.bg};
    end
    if (b_leave) begin
      win_l <= win_m;
      win_m <= col3;
    end
    if (b_leave && b_filled) begin
      out_tok <= '{bg: bg, restart: b_first, emit: b_tok.emit, last: b_tok.last};
    end
  end

endmodule

>>> hdl/bm3_back.sv
// bm3_back: thresholds tokens and runs one or two window stages, then drives results
// uses bm3_pkg, bm3_stage, bm3_out_if
`timescale 1ns / 1ps

module bm3_back import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  input  logic [1:0]                      op,
  input  logic                            shape,
  input  logic [7:0]                      threshold,
  input  logic                            tok_valid,
  output logic                            tok_ready,
  input  tok_t                            tok,
  bm3_out_if.source                       results
);

  logic  single, kind1, kind2;
  stok_t s1_in, s1_out, s2_out, fin;
  logic  s1_out_valid, s1_out_ready, s2_in_valid, s2_in_ready;
  logic  s2_out_valid, s2_out_ready, fin_valid;

  assign single = (op == OP_DILATE) || (op == OP_ERODE);
  assign kind1  = (op == OP_ERODE || op == OP_OPEN) ? KIND_ERODE : KIND_DILATE;
  assign kind2  = (op == OP_CLOSE) ? KIND_ERODE : KIND_DILATE;

  assign s1_in = '{bg: (tok.luma >= threshold), restart: tok.restart,
                   emit: tok.emit, last: tok.last};

  bm3_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_stage1 (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .height    (height),
    .shape     (shape),
    .kind      (kind1),
    .in_valid  (tok_valid),
    .in_ready  (tok_ready),
    .in_tok    (s1_in),
    .out_valid (s1_out_valid),
    .out_ready (s1_out_ready),
    .out_tok   (s1_out)
  );

  assign s2_in_valid  = s1_out_valid && !single;
  // silent tokens leave without waiting on the result channel
  assign s1_out_ready = single ? (results.ready || !s1_out.emit) : s2_in_ready;

  bm3_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_stage2 (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .height    (height),
    .shape     (shape),
    .kind      (kind2),
    .in_valid  (s2_in_valid),
    .in_ready  (s2_in_ready),
    .in_tok    (s1_out),
    .out_valid (s2_out_valid),
    .out_ready (s2_out_ready),
    .out_tok   (s2_out)
  );

  assign s2_out_ready = results.ready || !s2_out.emit;

  assign fin_valid         = single ? s1_out_valid : s2_out_valid;
  assign fin               = single ? s1_out : s2_out;
  assign results.valid     = fin_valid && fin.emit;
  assign results.level     = fin.bg ? LEVEL_BG : LEVEL_FG;
  assign results.frame_end = fin.last;

endmodule

>>> hdl/binary_morphology_3x3_core.sv
// channel     dir  handshake     payload
// pixels      in   valid/ready   cmd, red, green, blue
// results     out  valid/ready   level, frame_end
// cfg_*       in   write enable  cfg_index, cfg_data
//
// one item per cycle while results are not stalled; the line-store ram in each window stage
// is read and written once per item. results trail their pixels by width+1
// items (dilate, erode) or 2*width+2 (open, close).
// a flush that starts the tail of a frame shorter than the latency waits while
// latency minus frame size silent tokens fill the window stages.
// reset is synchronous; the queue lets the front take items while results stall.
//
// top level: configuration registers, front end, token queue, back end
// uses bm3_pkg, bm3_in_if, bm3_out_if, bm3_front, bm3_queue, bm3_back
`timescale 1ns / 1ps

module binary_morphology_3x3_core import bm3_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  bm3_in_if.sink                 pixels,
  bm3_out_if.source              results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WD_W = $clog2(MAX_WIDTH+1);
  localparam int HT_W = $clog2(MAX_HEIGHT+1);
  localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [WD_W-1:0] width;
  logic [HT_W-1:0] height;
  logic [1:0]      op;
  logic            shape;
  logic [7:0]      threshold;
  logic            restart;

  logic f_valid, f_ready, q_valid, q_ready;
  tok_t f_tok, q_tok;

  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_OPERATION,
        REG_ELEMENT_SHAPE, REG_LUMA_THRESHOLD: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= WD_W'(WIDTH_RST);
      height    <= HT_W'(HEIGHT_RST);
      op        <= OP_DILATE;
      shape     <= SHAPE_CROSS;
      threshold <= LUMA_THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            width <= WD_W'(1);
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            width <= WD_W'(MAX_WIDTH);
          end else begin
            width <= WD_W'(cfg_data);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            height <= HT_W'(1);
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            height <= HT_W'(MAX_HEIGHT);
          end else begin
            height <= HT_W'(cfg_data);
          end
        end
        REG_OPERATION:      op        <= cfg_data[1:0];
        REG_ELEMENT_SHAPE:  shape     <= cfg_data[0];
        REG_LUMA_THRESHOLD: threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bm3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .width     (width),
    .height    (height),
    .op        (op),
    .pixels    (pixels),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  bm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  bm3_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .height    (height),
    .op        (op),
    .shape     (shape),
    .threshold (threshold),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .results   (results)
  );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for binary_morphology_3x3_core, threshold plus 3x3 morphology
// depends on bm3_pkg, bm3_in_if, bm3_out_if and the core; keeps its own pixel-exact predictor
`timescale 1ns / 1ps

module tb_top;
  import bm3_pkg::*;

  typedef struct {
    logic [7:0] level;
    logic       frame_end;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bm3_in_if pin();
  bm3_out_if pout();

  binary_morphology_3x3_core uut (
    .clk(clk), .rst(rst), .pixels(pin), .results(pout),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  bit line_ring [8][1024];
  int fw, fh, in_col, in_row, out_col, out_row, pend;
  logic [1:0] op;
  logic shape;
  logic [7:0] thr;
  result_t expected_q [$];

  int errors = 0, items_sent = 0, results_seen = 0, flushes_sent = 0, frames_done = 0;
  int burst_left = 0;
  int cycles = 0;

  function automatic int clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  // kind 0 dilates (and of background), kind 1 erodes (or of background)
  function automatic bit pass_at(int r, int c, bit kind, int inner);
    bit acc;
    bit v;
    acc = (kind == KIND_DILATE) ? 1'b1 : 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (shape == SHAPE_CROSS && dr != 0 && dc != 0) continue;
        if (r + dr < 0 || c + dc < 0 || r + dr >= fh || c + dc >= fw) continue;
        if (inner < 0) v = line_ring[(r + dr) & 7][c + dc];
        else v = pass_at(r + dr, c + dc, bit'(inner), -1);
        if (kind == KIND_DILATE) acc &= v;
        else acc |= v;
      end
    end
    return acc;
  endfunction

  function automatic int latency_items();
    return (op == OP_DILATE || op == OP_ERODE) ? fw + 1 : 2 * fw + 2;
  endfunction

  function automatic void emit_result();
    bit bg;
    result_t res;
    case (op)
      OP_DILATE: bg = pass_at(out_row, out_col, KIND_DILATE, -1);
      OP_ERODE:  bg = pass_at(out_row, out_col, KIND_ERODE, -1);
      OP_OPEN:   bg = pass_at(out_row, out_col, KIND_DILATE, 1);
      default:   bg = pass_at(out_row, out_col, KIND_ERODE, 0);
    endcase
    res.level = bg ? LEVEL_BG : LEVEL_FG;
    res.frame_end = (out_row == fh - 1 && out_col == fw - 1);
    if (res.frame_end) frames_done++;
    expected_q.push_back(res);
    out_col++;
    if (out_col >= fw) begin
      out_col = 0;
      out_row++;
      if (out_row >= fh) out_row = 0;
    end
    pend--;
  endfunction

  function automatic void predict_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    bit at_start;
    int unsigned y;
    at_start = (in_row == 0 && in_col == 0);
    if (cmd == CMD_PIXEL) begin
      y = (13933 * r + 46871 * g + 4732 * b + 32768) >> 16;
      // new frame without a flush drops the old tail
      if (at_start && pend > 0) begin
        pend = 0;
        out_row = 0;
        out_col = 0;
      end
      line_ring[in_row & 7][in_col] = (y >= thr);
      in_col++;
      if (in_col >= fw) begin
        in_col = 0;
        in_row++;
        if (in_row >= fh) in_row = 0;
      end
      pend++;
      if (pend > latency_items()) emit_result();
    end else if (at_start && pend > 0) begin
      emit_result();
    end
  endfunction

  function automatic void restart_stream();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; pend = 0;
  endfunction

  // one item on the pixel channel, with bursty gaps
  task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pin.valid <= 1'b1;
    pin.cmd <= cmd;
    pin.red <= r;
    pin.green <= g;
    pin.blue <= b;
    do @(posedge clk); while (!pin.ready);
    predict_item(cmd, r, g, b);
    items_sent++;
    if (cmd == CMD_FLUSH) flushes_sent++;
  endtask

  task automatic send_pixel();
    logic [7:0] v;
    if ($urandom_range(0, 2) == 0) begin
      // gray near the threshold exercises the compare edge
      v = 8'(int'(thr) + $urandom_range(0, 4) - 2);
      send_item(CMD_PIXEL, v, v, v);
    end else begin
      send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain_flushes();
    while (pend > 0 && in_row == 0 && in_col == 0)
      send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    pin.valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (2 * fw + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:    fw = clamp_dim(val);
      REG_FRAME_HEIGHT:   fh = clamp_dim(val);
      REG_OPERATION:      op = val[1:0];
      REG_ELEMENT_SHAPE:  shape = val[0];
      REG_LUMA_THRESHOLD: thr = val[7:0];
      default: ;
    endcase
    restart_stream();
  endtask

  task automatic setup(int w, int h, logic [1:0] o, logic s, logic [7:0] t);
    write_reg(REG_FRAME_WIDTH, 11'(w));
    write_reg(REG_FRAME_HEIGHT, 11'(h));
    write_reg(REG_OPERATION, 11'(o));
    write_reg(REG_ELEMENT_SHAPE, 11'(s));
    write_reg(REG_LUMA_THRESHOLD, 11'(t));
  endtask

  task automatic send_frame();
    repeat (fw * fh) send_pixel();
    drain_flushes();
  endtask

  // a few pixels at reset geometry, then a register write throws them away
  task automatic test_reset_state();
    repeat (8) send_pixel();
    send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_directed();
    // every operation and shape on a 3x3 frame, colour extremes
    setup(3, 3, OP_DILATE, SHAPE_CROSS, 8'd0);
    for (int i = 0; i < 9; i++)
      send_item(CMD_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'hff : 8'h00, 8'hff);
    drain_flushes();
    write_reg(REG_LUMA_THRESHOLD, 11'd255);
    for (int o = 0; o < 4; o++) begin
      write_reg(REG_OPERATION, 11'(o));
      for (int s = 0; s < 2; s++) begin
        write_reg(REG_ELEMENT_SHAPE, 11'(s));
        write_reg(REG_LUMA_THRESHOLD, 11'(128));
        // flush with nothing pending, then a flush mid-frame
        send_item(CMD_FLUSH, 8'hff, 8'hff, 8'hff);
        for (int i = 0; i < 9; i++) begin
          if (i == 4) send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
          send_item(CMD_PIXEL, (i == 4) ? 8'h00 : 8'hff, 8'hff, (i == 4) ? 8'h00 : 8'hff);
        end
        drain_flushes();
      end
    end
    // missing flush: the next frame starts while the tail is pending
    repeat (9) send_pixel();
    repeat (9) send_pixel();
    drain_flushes();
  endtask

  // clamped geometry; only the head of a long frame is sent
  task automatic test_geometry_extremes();
    setup(0, 0, OP_CLOSE, SHAPE_SQUARE, 8'd100);
    send_frame();
    send_frame();
    setup(2047, 2, OP_OPEN, SHAPE_SQUARE, 8'd128);
    repeat (40) send_pixel();
    setup(1, 2047, OP_CLOSE, SHAPE_CROSS, 8'd128);
    repeat (60) send_pixel();
    setup(2047, 1, OP_ERODE, SHAPE_CROSS, 8'd60);
    repeat (40) send_pixel();
  endtask

  task automatic test_random();
    int target;
    int n;
    bit paused = 0;
    target = items_sent + 350;
    while (items_sent < target) begin
      setup($urandom_range(1, 8), $urandom_range(1, 6), 2'($urandom_range(0, 3)),
            1'($urandom_range(0, 1)), 8'($urandom));
      n = $urandom_range(1, 4);
      for (int f = 0; f < n; f++) begin
        case ($urandom_range(0, 9))
          0: begin
            // broken: partial frame with stray flushes
            repeat ($urandom_range(1, fw * fh)) begin
              if ($urandom_range(0, 3) == 0) send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
              send_pixel();
            end
          end
          1: repeat (fw * fh) send_pixel();
          default: begin
            repeat (fw * fh) send_pixel();
            if (!paused) begin
              // hold off until every pending result is out
              paused = 1;
              pin.valid <= 1'b0;
              burst_left = 0;
              while (expected_q.size() > 0) @(posedge clk);
            end
            drain_flushes();
          end
        endcase
      end
      repeat (fw * fh) send_pixel();
      drain_flushes();
    end
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pout.ready <= 1'b1;
      1: pout.ready <= 1'($urandom_range(0, 1));
      2: pout.ready <= (cycles % 4 == 0);
      default: pout.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && pout.valid && pout.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result level=%0d frame_end=%0d", pout.level, pout.frame_end);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (pout.level !== exp_res.level) begin
          $error("level expected %0d actual %0d", exp_res.level, pout.level);
          errors++;
        end
        if (pout.frame_end !== exp_res.frame_end) begin
          $error("frame_end expected %0d actual %0d", exp_res.frame_end, pout.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("binary_morphology_3x3_core test failed");
      $finish;
    end
  end

  initial begin
    pin.valid = 1'b0;
    pin.cmd = CMD_PIXEL;
    pin.red = '0;
    pin.green = '0;
    pin.blue = '0;
    pout.ready = 1'b0;
    fw = FRAME_WIDTH_RST;
    fh = FRAME_HEIGHT_RST;
    op = OP_DILATE;
    shape = SHAPE_CROSS;
    thr = LUMA_THRESHOLD_RST;
    restart_stream();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_geometry_extremes();
    test_random();
    pin.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (2 * fw + 40) @(posedge clk);
    $display("covered %0d items (%0d flushes), %0d results, %0d frames completed",
             items_sent, flushes_sent, results_seen, frames_done);
    $display("all four operations, both elements, clamped geometry and dropped tails");
    if (errors == 0) begin
      $display("binary_morphology_3x3_core test passed");
    end else begin
      $display("binary_morphology_3x3_core test failed");
    end
    $finish;
  end

endmodule
